// File: rtl/s2u_pkg.sv
// s2u_pkg: types, character constants and digit decoding for the string to u64 parser
// no dependencies; used by string_to_u64_parser and s2u_chk
package s2u_pkg;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_ZERO   = 2'd1,
		PH_DIGITS = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;

	localparam logic [5:0] BASE_MIN   = 6'd2;
	localparam logic [5:0] BASE_MAX   = 6'd36;
	localparam logic [5:0] BASE_HEX   = 6'd16;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_OCT   = 6'd8;
	localparam logic [5:0] BASE_AUTO  = 6'd0;
	localparam logic [5:0] NOT_DIGIT  = 6'd63;

	function automatic logic base_ok(input logic [5:0] b);
		return (b >= BASE_MIN) && (b <= BASE_MAX);
	endfunction

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			t = c - CH_UPPER_A + 8'd10;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			t = c - CH_LOWER_A + 8'd10;
		end else begin
			t = {2'b00, NOT_DIGIT};
		end
		return t[5:0];
	endfunction

endpackage

// File: rtl/string_to_u64_parser.sv
// string_to_u64_parser: streaming unsigned number parser, one character per request
// depends on s2u_pkg
// a character is registered at acceptance and evaluated from that input register into the
//   result register; evaluation waits while a result is stalled at the output
// throughput: one character per cycle unless stalled, set by the single multiply-add acc*base
// reset: arst_n clears the parse state, the base register and both valid flags
module string_to_u64_parser #(
	parameter int VALUE_BITS  = 64,
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [5:0]             base,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             char_code,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   done_res,
	output logic [VALUE_BITS-1:0]  value,
	output logic [1:0]             status,
	output logic [OFFSET_BITS-1:0] end_offset
);

	localparam int WB = VALUE_BITS + 7;

	logic [5:0]             base_q;
	logic                   valid_s1;
	logic [7:0]             char_s1;

	s2u_pkg::phase_t        phase_q, phase_nxt;
	logic [5:0]             abase_q, abase_nxt;
	logic [VALUE_BITS-1:0]  acc_q, acc_nxt;
	logic                   rng_q, rng_nxt;
	logic                   any_q, any_nxt;
	logic                   hex_q, hex_nxt;
	logic [OFFSET_BITS-1:0] cnt_q, cnt_nxt;

	logic                   out_valid_q;
	logic [VALUE_BITS-1:0]  value_q;
	s2u_pkg::status_t       status_q;
	logic [OFFSET_BITS-1:0] offset_q;

	logic                   proceed, fire;
	logic                   emit, clear, to_zero, to_digits;
	logic [VALUE_BITS-1:0]  res_value;
	s2u_pkg::status_t       res_status;
	logic [OFFSET_BITS-1:0] res_offset;

	logic                   do_digit;
	logic [5:0]             beff;
	logic [VALUE_BITS-1:0]  acc_in;
	logic                   rng_in, any_in, hex_in;
	logic [OFFSET_BITS-1:0] cnt_in;
	logic [5:0]             dig;
	logic [WB-1:0]          wide;

	assign proceed  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && proceed;
	assign in_stall = valid_s1 && !proceed;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= s2u_pkg::BASE_AUTO;
		end else if (cfg_wr_en) begin
			base_q <= base;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
		end
	end

	assign dig  = s2u_pkg::digit_of(char_s1);
	assign wide = WB'(acc_in) * WB'(beff) + WB'(dig);

	// per character evaluation
	always_comb begin
		emit       = 1'b0;
		clear      = 1'b0;
		to_zero    = 1'b0;
		to_digits  = 1'b0;
		res_value  = '0;
		res_status = s2u_pkg::ST_OK;
		res_offset = '0;
		do_digit   = 1'b0;
		beff       = abase_q;
		acc_in     = acc_q;
		rng_in     = rng_q;
		any_in     = any_q;
		hex_in     = hex_q;
		cnt_in     = cnt_q;
		abase_nxt  = abase_q;
		acc_nxt    = acc_q;
		rng_nxt    = rng_q;
		any_nxt    = any_q;
		hex_nxt    = hex_q;
		cnt_nxt    = cnt_q;

		unique case (phase_q)
			s2u_pkg::PH_START: begin
				acc_in = '0;
				rng_in = 1'b0;
				any_in = 1'b0;
				hex_in = 1'b0;
				cnt_in = '0;
				if (char_s1 == s2u_pkg::CH_ZERO && (base_q == s2u_pkg::BASE_AUTO ||
						base_q == s2u_pkg::BASE_HEX || !s2u_pkg::base_ok(base_q))) begin
					to_zero   = 1'b1;
					abase_nxt = base_q;
				end else if (base_q != s2u_pkg::BASE_AUTO && !s2u_pkg::base_ok(base_q)) begin
					emit       = 1'b1;
					res_status = s2u_pkg::ST_INVALID;
				end else begin
					do_digit = 1'b1;
					beff     = (base_q == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_DEC : base_q;
				end
			end
			s2u_pkg::PH_ZERO: begin
				if (char_s1 == s2u_pkg::CH_LOWER_X || char_s1 == s2u_pkg::CH_UPPER_X) begin
					if (abase_q != s2u_pkg::BASE_AUTO && !s2u_pkg::base_ok(abase_q)) begin
						emit       = 1'b1;
						res_status = s2u_pkg::ST_OK;
					end else begin
						to_digits = 1'b1;
						abase_nxt = s2u_pkg::BASE_HEX;
						hex_nxt   = 1'b1;
						cnt_nxt   = OFFSET_BITS'(2);
					end
				end else if (abase_q != s2u_pkg::BASE_AUTO && !s2u_pkg::base_ok(abase_q)) begin
					emit       = 1'b1;
					res_status = s2u_pkg::ST_INVALID;
				end else begin
					// leading zero counts as a digit
					do_digit = 1'b1;
					beff     = (abase_q == s2u_pkg::BASE_AUTO) ? s2u_pkg::BASE_OCT
						: s2u_pkg::BASE_HEX;
					acc_in   = '0;
					rng_in   = 1'b0;
					any_in   = 1'b1;
					hex_in   = 1'b0;
					cnt_in   = OFFSET_BITS'(1);
				end
			end
			s2u_pkg::PH_DIGITS: begin
				if (s2u_pkg::base_ok(abase_q)) begin
					do_digit = 1'b1;
				end else begin
					clear = 1'b1;
				end
			end
			default: begin
				clear = 1'b1;
			end
		endcase

		if (do_digit) begin
			to_digits = 1'b1;
			abase_nxt = beff;
			if (dig >= beff) begin
				emit      = 1'b1;
				res_value = acc_in;
				if (rng_in) begin
					res_status = s2u_pkg::ST_RANGE;
					res_offset = cnt_in;
				end else if (any_in) begin
					res_status = s2u_pkg::ST_OK;
					res_offset = cnt_in;
				end else if (hex_in) begin
					res_status = s2u_pkg::ST_OK;
					res_offset = OFFSET_BITS'(1);
				end else begin
					res_status = s2u_pkg::ST_INVALID;
					res_offset = cnt_in;
				end
			end else begin
				cnt_nxt = (&cnt_in) ? cnt_in : cnt_in + 1'b1;
				any_nxt = 1'b1;
				hex_nxt = hex_in;
				if (rng_in) begin
					acc_nxt = acc_in;
					rng_nxt = 1'b1;
				end else if (|wide[WB-1:VALUE_BITS]) begin
					acc_nxt = '1;
					rng_nxt = 1'b1;
				end else begin
					acc_nxt = wide[VALUE_BITS-1:0];
					rng_nxt = 1'b0;
				end
			end
		end

		if (emit || clear) begin
			abase_nxt = '0;
			acc_nxt   = '0;
			rng_nxt   = 1'b0;
			any_nxt   = 1'b0;
			hex_nxt   = 1'b0;
			cnt_nxt   = '0;
		end
	end

	// next phase
	always_comb begin
		priority if (emit || clear) begin
			phase_nxt = s2u_pkg::PH_START;
		end else if (to_zero) begin
			phase_nxt = s2u_pkg::PH_ZERO;
		end else if (to_digits) begin
			phase_nxt = s2u_pkg::PH_DIGITS;
		end else begin
			phase_nxt = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= s2u_pkg::PH_START;
			abase_q <= '0;
			acc_q   <= '0;
			rng_q   <= 1'b0;
			any_q   <= 1'b0;
			hex_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			abase_q <= abase_nxt;
			acc_q   <= acc_nxt;
			rng_q   <= rng_nxt;
			any_q   <= any_nxt;
			hex_q   <= hex_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			value_q  <= res_value;
			status_q <= res_status;
			offset_q <= res_offset;
		end
	end

	assign out_valid  = out_valid_q;
	assign done_res   = out_valid_q;
	assign value      = value_q;
	assign status     = status_q;
	assign end_offset = offset_q;

endmodule

// File: rtl/s2u_chk.sv
// s2u_chk: port level checks for string_to_u64_parser, attached by bind
// depends on s2u_pkg and string_to_u64_parser
module s2u_chk #(
	parameter int VALUE_BITS  = 64,
	parameter int OFFSET_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic                   done_res,
	input logic [VALUE_BITS-1:0]  value,
	input logic [1:0]             status,
	input logic [OFFSET_BITS-1:0] end_offset
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status)
			&& $stable(end_offset))
		else $error("stalled result changed");

	// requests are only held back by a waiting result
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("request stalled without a waiting result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> done_res && (status == s2u_pkg::ST_OK || status == s2u_pkg::ST_INVALID
			|| status == s2u_pkg::ST_RANGE))
		else $error("bad status or done flag");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == s2u_pkg::ST_INVALID |-> value == '0)
		else $error("invalid result with nonzero value");

	a_range_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == s2u_pkg::ST_RANGE |-> (&value) && end_offset != '0)
		else $error("range result not saturated");

endmodule

bind string_to_u64_parser s2u_chk #(
	.VALUE_BITS(VALUE_BITS),
	.OFFSET_BITS(OFFSET_BITS)
) u_s2u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.done_res(done_res),
	.value(value),
	.status(status),
	.end_offset(end_offset)
);
